### src/mdp_pkg.sv
// shared widths, register indexes, reset values and pipeline control type
`timescale 1ns / 1ps

package mdp_pkg;

    localparam int MAX_IMAGE_SIDE = 2048;

    localparam int DEPTH_W  = 16;
    localparam int MASK_W   = 8;
    localparam int PIX_W    = 11;
    localparam int INV_W    = 25;
    localparam int CTR_W    = 12;
    localparam int SCALE_W  = 16;
    localparam int COORD_W  = 24;
    localparam int Z_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // split point of the reciprocal for the two partial products
    localparam int INV_LO_W = 13;
    localparam int INV_HI_W = INV_W - INV_LO_W;
    localparam int MZ_W     = CTR_W + Z_W;
    localparam int SUM_W    = MZ_W + INV_W + 1;
    localparam int FRAC_W   = 25;
    localparam int Q_W      = SUM_W - FRAC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X_HALF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y_HALF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MASK     = 3'd5;

    localparam logic [INV_W-1:0]   RST_INV_FOCAL   = 25'd43993;
    localparam logic [CTR_W-1:0]   RST_CENTER_X    = 12'd641;
    localparam logic [CTR_W-1:0]   RST_CENTER_Y    = 12'd481;
    localparam logic [SCALE_W-1:0] RST_DEPTH_SCALE = 16'd256;
    localparam logic [MASK_W-1:0]  RST_SKIP_MASK   = 8'd255;

    localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;

    // per-stage advance strobes for the axis datapath
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_stage_adv;

endpackage

### src/mdp_in_if.sv
// pixel input channel
`timescale 1ns / 1ps

interface mdp_in_if;
    import mdp_pkg::*;

    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth_value;
    logic               depth_is_nan;
    logic [MASK_W-1:0]  mask_value;
    logic [PIX_W-1:0]   pixel_row;
    logic [PIX_W-1:0]   pixel_column;

    modport source (output valid, depth_value, depth_is_nan, mask_value, pixel_row,
                    pixel_column, input ready);
    modport sink (input valid, depth_value, depth_is_nan, mask_value, pixel_row,
                  pixel_column, output ready);
endinterface

### src/mdp_out_if.sv
// point output channel
`timescale 1ns / 1ps

interface mdp_out_if;
    import mdp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic        [Z_W-1:0]     point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

### src/mdp_axis.sv
// one axis of the back-projection: offset times z times reciprocal, rounded and saturated
`timescale 1ns / 1ps

module mdp_axis
    import mdp_pkg::*;
(
    input  logic                      i_clk,
    input  t_stage_adv                i_adv,
    input  logic [CTR_W-1:0]          i_mag,
    input  logic                      i_neg,
    input  logic [Z_W-1:0]            i_z,
    input  logic [INV_W-1:0]          i_inv,
    output logic signed [COORD_W-1:0] o_coord
);

    logic [MZ_W-1:0]              r_mz3;
    logic                         r_neg3;
    logic [MZ_W+INV_LO_W-1:0]     r_lo4;
    logic [MZ_W+INV_HI_W-1:0]     r_hi4;
    logic                         r_neg4;
    logic [Q_W-1:0]               r_q5;
    logic                         r_neg5;
    logic [COORD_W-1:0]           r_coord6;

    logic [SUM_W-1:0]   n_sum;
    logic [COORD_W-1:0] n_coord;

    always_comb begin
        n_sum = {1'b0, r_hi4, {INV_LO_W{1'b0}}}
              + {{(SUM_W-MZ_W-INV_LO_W){1'b0}}, r_lo4}
              + (SUM_W'(1) << (FRAC_W - 1));
    end

    always_comb begin
        if (r_neg5) begin
            if (r_q5 >= Q_W'(COORD_MIN)) begin
                n_coord = COORD_MIN;
            end else begin
                n_coord = -r_q5[COORD_W-1:0];
            end
        end else begin
            if (r_q5 > Q_W'(COORD_MAX)) begin
                n_coord = COORD_MAX;
            end else begin
                n_coord = r_q5[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_mz3  <= i_mag * i_z;
            r_neg3 <= i_neg;
        end
        if (i_adv.s4) begin
            r_lo4  <= r_mz3 * i_inv[INV_LO_W-1:0];
            r_hi4  <= r_mz3 * i_inv[INV_W-1:INV_LO_W];
            r_neg4 <= r_neg3;
        end
        if (i_adv.s5) begin
            r_q5   <= n_sum[SUM_W-1:FRAC_W];
            r_neg5 <= r_neg4;
        end
        if (i_adv.s6) begin
            r_coord6 <= n_coord;
        end
    end

    assign o_coord = r_coord6;

endmodule

### src/masked_depth_to_point.sv
// pinhole back-projection of masked depth pixels to 3d points
`timescale 1ns / 1ps
// a pixel passes through all six stages in order; stage 6 is the output register
// throughput: one pixel per cycle while the output is not stalled; products in stages 1, 3, 4
// skipped pixels (no depth, masked, off image) leave the pipeline as bubbles at stage one
// a stalled output holds only the stages behind it that are full; empty stages keep filling
// reset (synchronous, active low) empties the pipeline and loads the default camera registers

module masked_depth_to_point
    import mdp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mdp_in_if.sink                i_pix,
    mdp_out_if.source             o_pt,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [INV_W-1:0]   r_inv_fx;
    logic [INV_W-1:0]   r_inv_fy;
    logic [CTR_W-1:0]   r_cx;
    logic [CTR_W-1:0]   r_cy;
    logic [SCALE_W-1:0] r_scale;
    logic [MASK_W-1:0]  r_skip;

    // valid bits, one per stage
    logic [6:1] r_v;
    logic [6:1] adv;
    t_stage_adv axis_adv;

    // stage 1: raw depth product and pixel offsets
    logic [DEPTH_W+SCALE_W-1:0] r_prod1;
    logic [CTR_W-1:0]           r_magx1, r_magy1;
    logic                       r_negx1, r_negy1;
    // stage 2: scaled depth and offsets
    logic [Z_W-1:0]             r_z2;
    logic [CTR_W-1:0]           r_magx2, r_magy2;
    logic                       r_negx2, r_negy2;
    // z rides along with the axis datapath
    logic [Z_W-1:0]             r_z3, r_z4, r_z5, r_z6;

    logic                       n_keep;
    logic [CTR_W-1:0]           twice_col, twice_row;
    logic                       n_negx, n_negy;
    logic [CTR_W-1:0]           n_magx, n_magy;
    logic [DEPTH_W+SCALE_W:0]   n_zsum;
    logic [Z_W-1:0]             n_z;

    logic signed [COORD_W-1:0]  point_x6, point_y6;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_fx <= RST_INV_FOCAL;
            r_inv_fy <= RST_INV_FOCAL;
            r_cx     <= RST_CENTER_X;
            r_cy     <= RST_CENTER_Y;
            r_scale  <= RST_DEPTH_SCALE;
            r_skip   <= RST_SKIP_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INV_FOCAL_X:   r_inv_fx <= i_cfg_data[INV_W-1:0];
                CFG_INV_FOCAL_Y:   r_inv_fy <= i_cfg_data[INV_W-1:0];
                CFG_CENTER_X_HALF: r_cx     <= i_cfg_data[CTR_W-1:0];
                CFG_CENTER_Y_HALF: r_cy     <= i_cfg_data[CTR_W-1:0];
                CFG_DEPTH_SCALE:   r_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_SKIP_MASK:     r_skip   <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage moves on when it is empty or the one ahead moves on
    always_comb begin
        adv[6] = !r_v[6] || o_pt.ready;
        adv[5] = !r_v[5] || adv[6];
        adv[4] = !r_v[4] || adv[5];
        adv[3] = !r_v[3] || adv[4];
        adv[2] = !r_v[2] || adv[3];
        adv[1] = !r_v[1] || adv[2];
    end

    assign i_pix.ready = adv[1];

    assign axis_adv.s3 = adv[3];
    assign axis_adv.s4 = adv[4];
    assign axis_adv.s5 = adv[5];
    assign axis_adv.s6 = adv[6];

    // skip decision and signed offsets from the principal point in half pixels
    always_comb begin
        n_keep = !i_pix.depth_is_nan
              && (i_pix.mask_value != r_skip)
              && (32'(i_pix.pixel_row) < MAX_IMAGE_SIDE)
              && (32'(i_pix.pixel_column) < MAX_IMAGE_SIDE);

        twice_col = {i_pix.pixel_column, 1'b0};
        twice_row = {i_pix.pixel_row, 1'b0};
        n_negx    = r_cx > twice_col;
        n_negy    = r_cy > twice_row;
        n_magx    = n_negx ? (r_cx - twice_col) : (twice_col - r_cx);
        n_magy    = n_negy ? (r_cy - twice_row) : (twice_row - r_cy);
    end

    // z: round the q24.8 product of depth and q8.8 scale and clip to 16 bits
    always_comb begin
        n_zsum = {1'b0, r_prod1} + (DEPTH_W+SCALE_W+1)'(128);
        if (|n_zsum[DEPTH_W+SCALE_W:Z_W+8]) begin
            n_z = '1;
        end else begin
            n_z = n_zsum[Z_W+7:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[1]) r_v[1] <= i_pix.valid && n_keep;
            if (adv[2]) r_v[2] <= r_v[1];
            if (adv[3]) r_v[3] <= r_v[2];
            if (adv[4]) r_v[4] <= r_v[3];
            if (adv[5]) r_v[5] <= r_v[4];
            if (adv[6]) r_v[6] <= r_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_prod1 <= i_pix.depth_value * r_scale;
            r_magx1 <= n_magx;
            r_magy1 <= n_magy;
            r_negx1 <= n_negx;
            r_negy1 <= n_negy;
        end
        if (adv[2]) begin
            r_z2    <= n_z;
            r_magx2 <= r_magx1;
            r_magy2 <= r_magy1;
            r_negx2 <= r_negx1;
            r_negy2 <= r_negy1;
        end
        if (adv[3]) r_z3 <= r_z2;
        if (adv[4]) r_z4 <= r_z3;
        if (adv[5]) r_z5 <= r_z4;
        if (adv[6]) r_z6 <= r_z5;
    end

    mdp_axis u_axis_x (
        .i_clk   (i_clk),
        .i_adv   (axis_adv),
        .i_mag   (r_magx2),
        .i_neg   (r_negx2),
        .i_z     (r_z2),
        .i_inv   (r_inv_fx),
        .o_coord (point_x6)
    );

    mdp_axis u_axis_y (
        .i_clk   (i_clk),
        .i_adv   (axis_adv),
        .i_mag   (r_magy2),
        .i_neg   (r_negy2),
        .i_z     (r_z2),
        .i_inv   (r_inv_fy),
        .o_coord (point_y6)
    );

    // stage 6 is the output register
    assign o_pt.valid   = r_v[6];
    assign o_pt.point_x = point_x6;
    assign o_pt.point_y = point_y6;
    assign o_pt.point_z = r_z6;

endmodule

### src/mdp_checker.sv
// port-level checks for the back-projection block, bound to the top level
`timescale 1ns / 1ps

module mdp_checker
    import mdp_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic signed [COORD_W-1:0] i_point_x,
    input logic signed [COORD_W-1:0] i_point_y,
    input logic        [Z_W-1:0]     i_point_z
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("point shown right after reset");

    // a free output means every stage can move, so the input is open
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input blocked while output is free");

    // zero z gives a point at the origin
    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_point_z == '0) |-> (i_point_x == '0 && i_point_y == '0))
        else $error("nonzero x or y with zero z");

    // a stalled point holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_point_x) && $stable(i_point_y) && $stable(i_point_z)))
        else $error("stalled point changed");

endmodule

bind masked_depth_to_point mdp_checker u_mdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pt.valid),
    .i_out_ready (o_pt.ready),
    .i_point_x   (o_pt.point_x),
    .i_point_y   (o_pt.point_y),
    .i_point_z   (o_pt.point_z)
);

### tb/testbench.sv
// testbench for masked_depth_to_point: random and directed pixels checked against a point predictor
`timescale 1ns / 1ps

import mdp_pkg::*;

typedef struct packed {
    logic [DEPTH_W-1:0] depth_value;
    logic               depth_is_nan;
    logic [MASK_W-1:0]  mask_value;
    logic [PIX_W-1:0]   pixel_row;
    logic [PIX_W-1:0]   pixel_column;
} t_pixel;

typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic        [Z_W-1:0]     point_z;
} t_point;

typedef struct packed {
    logic [INV_W-1:0]   inv_fx;
    logic [INV_W-1:0]   inv_fy;
    logic [CTR_W-1:0]   center_x;
    logic [CTR_W-1:0]   center_y;
    logic [SCALE_W-1:0] scale;
    logic [MASK_W-1:0]  skip;
} t_camera;

// keeps the camera registers, predicts each point and holds those still to arrive
class t_point_tracker;
    t_camera cam;
    t_point  pending_points[$];
    int      failures;

    function new();
        cam.inv_fx   = RST_INV_FOCAL;
        cam.inv_fy   = RST_INV_FOCAL;
        cam.center_x = RST_CENTER_X;
        cam.center_y = RST_CENTER_Y;
        cam.scale    = RST_DEPTH_SCALE;
        cam.skip     = RST_SKIP_MASK;
        failures     = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_INV_FOCAL_X:   cam.inv_fx   = data[INV_W-1:0];
            CFG_INV_FOCAL_Y:   cam.inv_fy   = data[INV_W-1:0];
            CFG_CENTER_X_HALF: cam.center_x = data[CTR_W-1:0];
            CFG_CENTER_Y_HALF: cam.center_y = data[CTR_W-1:0];
            CFG_DEPTH_SCALE:   cam.scale    = data[SCALE_W-1:0];
            CFG_SKIP_MASK:     cam.skip     = data[MASK_W-1:0];
            default: ;
        endcase
    endfunction

    // an 11-bit row or column can never reach the image side, so only nan and mask matter
    function bit yields_point(t_pixel p);
        return !p.depth_is_nan && (p.mask_value != cam.skip);
    endfunction

    // offset from the principal point times z times 1/f, rounded half away from zero
    function logic [COORD_W-1:0] project_axis(logic [PIX_W-1:0] pix, logic [CTR_W-1:0] ctr,
                                              logic [Z_W-1:0] z, logic [INV_W-1:0] inv);
        longint unsigned twice, mag, prod, q;
        bit              neg;
        twice = {pix, 1'b0};
        neg   = ctr > twice;
        mag   = neg ? ctr - twice : twice - ctr;
        prod  = mag * z * inv;
        q     = (prod + (64'd1 << 24)) >> 25;
        if (neg)
            return (q >= 64'd8388608) ? COORD_MIN : COORD_W'(64'd0 - q);
        return (q > 64'd8388607) ? COORD_MAX : COORD_W'(q);
    endfunction

    function t_point backproject(t_pixel p);
        t_point          pt;
        longint unsigned zw;
        zw      = (longint'(p.depth_value) * cam.scale + 128) >> 8;
        pt.point_z = (zw > 64'hFFFF) ? 16'hFFFF : zw[Z_W-1:0];
        pt.point_x = project_axis(p.pixel_column, cam.center_x, pt.point_z, cam.inv_fx);
        pt.point_y = project_axis(p.pixel_row, cam.center_y, pt.point_z, cam.inv_fy);
        return pt;
    endfunction

    function void note_pixel(t_pixel p);
        if (yields_point(p))
            pending_points = {pending_points, backproject(p)};
    endfunction

    function void check_point(t_point got);
        t_point want;
        if (pending_points.size() == 0) begin
            $display("%0t: unexpected point x %0d y %0d z %0d", $time,
                     $signed(got.point_x), $signed(got.point_y), got.point_z);
            failures++;
            return;
        end
        want = pending_points.pop_front();
        if (got.point_x !== want.point_x) begin
            $display("%0t: point_x expected %0d actual %0d", $time,
                     $signed(want.point_x), $signed(got.point_x));
            failures++;
        end
        if (got.point_y !== want.point_y) begin
            $display("%0t: point_y expected %0d actual %0d", $time,
                     $signed(want.point_y), $signed(got.point_y));
            failures++;
        end
        if (got.point_z !== want.point_z) begin
            $display("%0t: point_z expected %0d actual %0d", $time, want.point_z, got.point_z);
            failures++;
        end
    endfunction

    function int outstanding();
        return pending_points.size();
    endfunction
endclass

module testbench;

    // six stages from pixel to point, plus some margin
    localparam int PIPE_LATENCY   = 6;
    localparam int SETTLE_CYCLES  = PIPE_LATENCY + 4;
    localparam int WATCHDOG_LIMIT = 2000;

    // register indexes past the end of the list, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int quiet_cycles = 0;

    t_point_tracker tracker;

    mdp_in_if  pix_if();
    mdp_out_if pt_if();

    masked_depth_to_point DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_pt       (pt_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver back-pressure, redrawn every falling edge
    always @(negedge i_clk) begin
        pt_if.ready = (snk_idle_pct == 0) || ($urandom_range(99) >= snk_idle_pct);
    end

    // both handshakes sampled at the rising edge; the watchdog watches for a stuck pipeline
    always @(posedge i_clk) begin
        t_pixel taken;
        t_point seen;
        bit     moved;
        moved = 1'b0;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            taken.depth_value  = pix_if.depth_value;
            taken.depth_is_nan = pix_if.depth_is_nan;
            taken.mask_value   = pix_if.mask_value;
            taken.pixel_row    = pix_if.pixel_row;
            taken.pixel_column = pix_if.pixel_column;
            tracker.note_pixel(taken);
            moved = 1'b1;
        end
        if (i_rst_n && pt_if.valid && pt_if.ready) begin
            seen.point_x = pt_if.point_x;
            seen.point_y = pt_if.point_y;
            seen.point_z = pt_if.point_z;
            tracker.check_point(seen);
            moved = 1'b1;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("masked_depth_to_point verification failed");
            $finish;
        end
    end

    function automatic t_pixel make_pixel(logic [DEPTH_W-1:0] depth, logic nan,
                                          logic [MASK_W-1:0] mask, logic [PIX_W-1:0] row,
                                          logic [PIX_W-1:0] col);
        t_pixel p;
        p.depth_value  = depth;
        p.depth_is_nan = nan;
        p.mask_value   = mask;
        p.pixel_row    = row;
        p.pixel_column = col;
        return p;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance with valid still high
    task automatic send_pixel(input t_pixel p);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            pix_if.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid        = 1'b1;
        pix_if.depth_value  = p.depth_value;
        pix_if.depth_is_nan = p.depth_is_nan;
        pix_if.mask_value   = p.mask_value;
        pix_if.pixel_row    = p.pixel_row;
        pix_if.pixel_column = p.pixel_column;
        do @(posedge i_clk); while (!pix_if.ready);
        @(negedge i_clk);
    endtask

    // mostly usable pixels; a tenth each with no depth or with the skip mask
    function automatic t_pixel random_pixel();
        t_pixel p;
        case ($urandom_range(7))
            0:       p.depth_value = '0;
            1:       p.depth_value = '1;
            2:       p.depth_value = DEPTH_W'($urandom_range(1, 255));
            default: p.depth_value = DEPTH_W'($urandom);
        endcase
        p.depth_is_nan = ($urandom_range(9) == 0);
        p.mask_value   = ($urandom_range(9) == 0) ? tracker.cam.skip : MASK_W'($urandom);
        p.pixel_row    = PIX_W'($urandom);
        p.pixel_column = PIX_W'($urandom);
        return p;
    endfunction

    // sends a run of random pixels
    task automatic send_random(input int count);
        t_pixel p;
        repeat (count) begin
            p = random_pixel();
            send_pixel(p);
        end
    endtask

    // stop the stream, wait for every point owed and let skipped pixels drain
    task automatic quiesce();
        pix_if.valid = 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        tracker.write_register(idx, data);
        @(negedge i_clk);
    endtask

    // narrow registers get random junk above their width, which the block must drop
    task automatic load_camera(input t_camera c);
        write_reg(CFG_INV_FOCAL_X, c.inv_fx);
        write_reg(CFG_INV_FOCAL_Y, c.inv_fy);
        write_reg(CFG_CENTER_X_HALF, {(CFG_DATA_W-CTR_W)'($urandom), c.center_x});
        write_reg(CFG_CENTER_Y_HALF, {(CFG_DATA_W-CTR_W)'($urandom), c.center_y});
        write_reg(CFG_DEPTH_SCALE, {(CFG_DATA_W-SCALE_W)'($urandom), c.scale});
        write_reg(CFG_SKIP_MASK, {(CFG_DATA_W-MASK_W)'($urandom), c.skip});
        write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
        cfg_we = 1'b0;
    endtask

    function automatic logic [INV_W-1:0] random_inverse();
        case ($urandom_range(3))
            0:       return INV_W'($urandom_range(1000, 20000));
            1:       return INV_W'($urandom_range(0, 1 << 24));
            2:       return INV_W'($urandom);
            default: return INV_W'($urandom_range(20000, 120000));
        endcase
    endfunction

    function automatic t_camera random_camera();
        t_camera c;
        c.inv_fx   = random_inverse();
        c.inv_fy   = random_inverse();
        c.center_x = CTR_W'($urandom);
        c.center_y = CTR_W'($urandom);
        c.scale    = ($urandom_range(1) == 0) ? SCALE_W'($urandom_range(128, 1024))
                                              : SCALE_W'($urandom);
        c.skip     = MASK_W'($urandom);
        return c;
    endfunction

    initial begin
        t_camera cam;
        tracker = new();

        // every input known from time zero
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        pix_if.valid        = 1'b0;
        pix_if.depth_value  = '0;
        pix_if.depth_is_nan = 1'b0;
        pix_if.mask_value   = '0;
        pix_if.pixel_row    = '0;
        pix_if.pixel_column = '0;
        pt_if.ready         = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // sender idles a little, receiver a lot
        src_idle_pct = 23;
        snk_idle_pct = 54;

        // reset camera: field extremes, both skip reasons, pixels either side of centre
        send_pixel(make_pixel('0, 1'b0, 8'h00, '0, '0));
        send_pixel(make_pixel('1, 1'b0, 8'h00, '1, '1));
        send_pixel(make_pixel('1, 1'b0, 8'h7F, '0, '0));
        send_pixel(make_pixel(16'd1000, 1'b1, 8'h00, 11'd100, 11'd100));
        send_pixel(make_pixel(16'd1000, 1'b0, 8'hFF, 11'd100, 11'd100));
        send_pixel(make_pixel(16'd1000, 1'b0, 8'hFE, 11'd240, 11'd320));
        send_pixel(make_pixel(16'd1000, 1'b0, 8'h01, 11'd241, 11'd321));
        send_pixel(make_pixel(16'd1, 1'b0, 8'h00, 11'd0, 11'd2047));
        send_pixel(make_pixel(16'h8000, 1'b0, 8'h80, 11'd1024, 11'd1024));
        send_pixel(make_pixel(16'h7FFF, 1'b0, 8'h55, 11'h555, 11'h2AA));
        send_pixel(make_pixel(16'h5555, 1'b0, 8'hAA, 11'h2AA, 11'h555));
        send_random(250);

        // extreme camera: reciprocals of 2^24 and full scale, full-scale depth scale, centre in opposite corners
        quiesce();
        cam.inv_fx   = 25'd16777216;
        cam.inv_fy   = '1;
        cam.center_x = '1;
        cam.center_y = '0;
        cam.scale    = '1;
        cam.skip     = '0;
        load_camera(cam);
        // both axes saturated, one each way, and z saturated
        send_pixel(make_pixel('1, 1'b0, 8'h01, '1, '0));
        send_pixel(make_pixel('1, 1'b0, 8'hFF, '0, '1));
        send_pixel(make_pixel(16'd1, 1'b0, 8'h00, 11'd5, 11'd5));
        send_pixel(make_pixel(16'd1, 1'b0, 8'hFF, 11'd5, 11'd5));
        send_pixel(make_pixel('0, 1'b1, 8'h00, 11'd5, 11'd5));
        send_random(250);

        // roles swapped: sender idles a lot, receiver a little
        src_idle_pct = 54;
        snk_idle_pct = 23;

        // zero camera: zero scale and reciprocals give zero coordinates
        quiesce();
        cam.inv_fx   = '0;
        cam.inv_fy   = '0;
        cam.center_x = '0;
        cam.center_y = '1;
        cam.scale    = '0;
        cam.skip     = '1;
        load_camera(cam);
        send_random(150);

        quiesce();
        load_camera(random_camera());
        send_random(250);

        // no idling on either side
        src_idle_pct = 0;
        snk_idle_pct = 0;

        quiesce();
        load_camera(random_camera());
        send_random(250);

        quiesce();
        load_camera(random_camera());
        send_random(250);

        quiesce();
        if (tracker.failures == 0) begin
            $display("masked_depth_to_point verification clean");
        end else begin
            $display("masked_depth_to_point verification failed");
        end
        $finish;
    end

endmodule

### files.f
src/mdp_pkg.sv
src/mdp_in_if.sv
src/mdp_out_if.sv
src/mdp_axis.sv
src/masked_depth_to_point.sv
src/mdp_checker.sv
tb/testbench.sv
